FILE: sv/spq_pkg.sv
// Shared types and constants for the stable priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // Default number of entries held
    localparam int DEPTH_DEFAULT = 16;

    // Field widths of one entry and of one result word
    localparam int VALUE_W   = 32;
    localparam int PRIO_W    = 16;
    localparam int ENTRY_W   = VALUE_W + PRIO_W;
    localparam int FILL_W    = 5;
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 56;

    // Operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // One result word from the sequencer
    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  head_value;
        logic signed [PRIO_W-1:0]   head_priority;
        logic [FILL_W-1:0]          fill_count;
    } res_t;

endpackage

`default_nettype wire

FILE: sv/spq_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
    parameter int WIDTH = spq_pkg::ENTRY_W,
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/spq_seq.sv
// Sequencer and shared compare unit: ordered insert and head removal over a ring in RAM.
`timescale 1ns / 1ps
`default_nettype none

module spq_seq #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic                                   opcode,
    input  wire logic signed [spq_pkg::VALUE_W-1:0]     item_value,
    input  wire logic signed [spq_pkg::PRIO_W-1:0]      item_priority,
    input  wire logic                                   res_ready,
    output logic                                        idle,
    output logic                                        res_valid,
    output spq_pkg::res_t                               res,
    output logic                                        ram_we,
    output logic [$clog2(DEPTH)-1:0]                    ram_waddr,
    output logic [spq_pkg::ENTRY_W-1:0]                 ram_wdata,
    output logic [$clog2(DEPTH)-1:0]                    ram_raddr,
    input  wire logic [spq_pkg::ENTRY_W-1:0]            ram_rdata
);

    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] FULL_N  = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_N   = CW'(1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_PUT   = 7'b0001000,
        S_DQRD  = 7'b0010000,
        S_DQCAP = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          head_reg, head_next;
    logic [CW-1:0]          occ_reg, occ_next;
    logic [AW-1:0]          cur_reg, cur_next;
    logic [CW-1:0]          rem_reg, rem_next;
    logic [VALUE_W-1:0]     val_reg, val_next;
    logic [PRIO_W-1:0]      pri_reg, pri_next;
    res_t                   res_reg, res_next;

    logic [AW:0]            tail_sum;
    logic [AW:0]            tail_wrap;
    logic [AW-1:0]          tail;
    logic                   stored_later;

    // Ring pointer step backwards / forwards
    function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
        return (p == '0) ? LAST : p - 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    // Fill count reported modulo 32
    function automatic logic [FILL_W-1:0] fill5(input logic [CW-1:0] n);
        logic [CW+FILL_W-1:0] e;
        e = {{FILL_W{1'b0}}, n};
        return e[FILL_W-1:0];
    endfunction

    // Physical slot just past the last entry
    assign tail_sum  = {1'b0, head_reg} + (AW + 1)'(occ_reg);
    assign tail_wrap = (tail_sum >= DEPTH_X) ? tail_sum - DEPTH_X : tail_sum;
    assign tail      = tail_wrap[AW-1:0];

    // Shared compare: stored entry must move up behind the newcomer
    assign stored_later = $signed(ram_rdata[ENTRY_W-1:VALUE_W]) > $signed(pri_reg);

    // Next-state and datapath control
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        occ_next   = occ_reg;
        cur_next   = cur_reg;
        rem_next   = rem_reg;
        val_next   = val_reg;
        pri_next   = pri_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = cur_reg;
        ram_wdata  = {pri_reg, val_reg};
        ram_raddr  = ptr_prev(cur_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    val_next = item_value;
                    pri_next = item_priority;
                    res_next.head_value    = '0;
                    res_next.head_priority = '0;
                    res_next.fill_count    = fill5(occ_reg);
                    if (opcode == OP_ENQ)
                    begin
                        if (occ_reg == FULL_N)
                        begin
                            res_next.status = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else if (occ_reg == '0)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = head_reg;
                            ram_wdata = {item_priority, item_value};
                            occ_next  = ONE_N;
                            res_next.status     = ST_ENQ;
                            res_next.fill_count = fill5(ONE_N);
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cur_next   = tail;
                            rem_next   = occ_reg;
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        if (occ_reg == '0)
                        begin
                            res_next.status = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_DQRD;
                        end
                    end
                end
            end

            // Fetch the entry below the hole
            S_RD:
            begin
                state_next = S_CMP;
            end

            // Either shift the entry up or drop the newcomer into the hole
            S_CMP:
            begin
                ram_we = 1'b1;
                if (stored_later)
                begin
                    ram_wdata  = ram_rdata;
                    cur_next   = ptr_prev(cur_reg);
                    rem_next   = rem_reg - 1'b1;
                    state_next = (rem_reg == ONE_N) ? S_PUT : S_RD;
                end
                else
                begin
                    occ_next            = occ_reg + 1'b1;
                    res_next.status     = ST_ENQ;
                    res_next.fill_count = fill5(occ_reg + 1'b1);
                    state_next          = S_DONE;
                end
            end

            // Newcomer goes to the head slot
            S_PUT:
            begin
                ram_we              = 1'b1;
                occ_next            = occ_reg + 1'b1;
                res_next.status     = ST_ENQ;
                res_next.fill_count = fill5(occ_reg + 1'b1);
                state_next          = S_DONE;
            end

            S_DQRD:
            begin
                ram_raddr  = head_reg;
                state_next = S_DQCAP;
            end

            // Head entry returned, ring start advances
            S_DQCAP:
            begin
                res_next.status        = ST_DEQ;
                res_next.head_value    = ram_rdata[VALUE_W-1:0];
                res_next.head_priority = ram_rdata[ENTRY_W-1:VALUE_W];
                res_next.fill_count    = fill5(occ_reg - 1'b1);
                occ_next               = occ_reg - 1'b1;
                head_next              = ptr_next(head_reg);
                state_next             = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            occ_reg   <= '0;
            cur_reg   <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            occ_reg   <= occ_next;
            cur_reg   <= cur_next;
            rem_reg   <= rem_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        pri_reg <= pri_next;
        res_reg <= res_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

`default_nettype wire

FILE: sv/stable_priority_queue.sv
// Top level of the stable priority queue: stream ports, sequencer, entry RAM, output register.
`timescale 1ns / 1ps
`default_nettype none

// Bounded priority queue of up to DEPTH entries (value, priority), kept sorted with
// lower priority first and equal priorities in arrival order. Each input word is one
// operation (tuser 0 enqueue, 1 dequeue); each yields exactly one result word. Entries
// live in a single RAM used as a ring, and one compare unit walks it under a small
// sequencer, so only one operation is in flight: the input is not ready while it runs.
// A dequeue reads the head slot and then captures its entry; an empty dequeue, a
// dropped enqueue or an enqueue into an empty queue finishes straight from idle. An
// enqueue walks back from the tail, moving up each stored entry of larger priority,
// and drops the newcomer into the hole, or into the head slot when it moves them all;
// each move costs one RAM read and one write. The input is ready again once the
// sequencer has handed its result to the output register. A finished result sits in
// the output register while the next word is taken; if that register is still full,
// the sequencer waits with its result until the register drains.

module stable_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [spq_pkg::S_DATA_W-1:0]   s_tdata,   // item_value[31:0], item_priority[47:32]
    input  wire logic [0:0]                     s_tuser,   // opcode[0]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [spq_pkg::M_DATA_W-1:0]        m_tdata,   // head_value[31:0], head_priority[47:32],
                                                           // fill_count[52:48], zero[55:53]
    output logic [1:0]                          m_tuser    // status[1:0]
);

    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic               seq_idle;
    logic               seq_start;
    logic               seq_res_valid;
    logic               seq_res_ready;
    res_t               seq_res;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic               out_valid_reg;
    res_t               out_res_reg;

    assign s_tready  = seq_idle;
    assign seq_start = s_tvalid & seq_idle;

    spq_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (seq_start),
        .opcode        (s_tuser[0]),
        .item_value    (s_tdata[VALUE_W-1:0]),
        .item_priority (s_tdata[ENTRY_W-1:VALUE_W]),
        .res_ready     (seq_res_ready),
        .idle          (seq_idle),
        .res_valid     (seq_res_valid),
        .res           (seq_res),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: takes a result when empty or being drained
    assign seq_res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (seq_res_ready)
        begin
            out_valid_reg <= seq_res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_res_ready && seq_res_valid)
        begin
            out_res_reg <= seq_res;
        end
    end

    // Result word packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {3'b000, out_res_reg.fill_count, out_res_reg.head_priority,
                       out_res_reg.head_value};

endmodule

`default_nettype wire

FILE: sv/spq_checker.sv
// Port-level checker for the stable priority queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module spq_checker #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [spq_pkg::M_DATA_W-1:0]   m_tdata,
    input  wire logic [1:0]                     m_tuser
);

    import spq_pkg::*;

    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

    // One operation at a time: input closes after each accepted word
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an operation was in flight");

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before it was taken");

    // Empty dequeue reports an empty queue
    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_EMPTY) |-> (m_tdata[52:48] == '0))
        else $error("empty status with non-zero fill count");

    // Dropped enqueue reports a full queue
    a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_FULL) |-> (m_tdata[52:48] == FULL_FILL))
        else $error("full status with wrong fill count");

    // Enqueue results carry no head entry
    a_enq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_ENQ) |-> (m_tdata[47:0] == '0))
        else $error("enqueue result carries head data");

endmodule

bind stable_priority_queue spq_checker #(
    .DEPTH (DEPTH)
) u_spq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
